// File: rtl/core/mnvd_pkg.sv
// Shared types and constants for the mesh normal, volume and de-duplication block.
package mnvd_pkg;

	// Internal coordinate width: a 16-bit field, sign or zero extended by one bit
	localparam int CW = 17;
	// Shared multiplier operand and product widths
	localparam int AW_OP = CW + 1;
	localparam int BW_OP = 2 * (CW + 1) + 1;
	localparam int PW = AW_OP + BW_OP;
	localparam int DOT_W = 56;

	typedef logic signed [CW-1:0] crd_t;
	typedef logic signed [BW_OP-1:0] crs_t;
	typedef logic signed [DOT_W-1:0] dot_t;

	typedef struct packed {
		crd_t x;
		crd_t y;
		crd_t z;
	} vtx_t;

	// Search result from the vertex table
	typedef struct packed {
		logic done;
		logic found;
		logic ovf;
	} tbl_res_t;

	// Results of the shared multiply unit
	typedef struct packed {
		logic        done;
		logic [31:0] sq;
		crs_t        cx;
		crs_t        cy;
		crs_t        cz;
		dot_t        dot;
	} ar_res_t;

endpackage

// File: rtl/core/mnvd_table.sv
// Vertex table: single-port memory searched linearly, one entry per cycle.
module mnvd_table #(
	parameter int TABLE_DEPTH = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              clear,
	input  mnvd_pkg::vtx_t    key,
	output mnvd_pkg::tbl_res_t res
);
	import mnvd_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int FW = $clog2(TABLE_DEPTH + 1);
	localparam logic [FW-1:0] DEPTH_F = FW'(TABLE_DEPTH);

	vtx_t          mem [TABLE_DEPTH];
	vtx_t          rdata_s1;
	vtx_t          key_q;
	logic          busy_q;
	logic          chk_s1;
	logic [FW-1:0] idx_q;
	logic [FW-1:0] fill_q;
	logic          done_q;
	logic          found_q;
	logic          ovf_q;

	logic hit;
	logic issue;
	logic miss;
	logic wr;

	// Compare the entry read last cycle; stop issuing on a hit
	assign hit   = chk_s1 && (rdata_s1 == key_q);
	assign issue = busy_q && !hit && (idx_q != fill_q);
	assign miss  = busy_q && !chk_s1 && (idx_q == fill_q);
	assign wr    = miss && (fill_q != DEPTH_F);

	// Memory: append on a miss unless full, registered read of the search address
	always_ff @(posedge clk) begin
		if (wr) begin
			mem[fill_q[AW-1:0]] <= key_q;
		end
		rdata_s1 <= mem[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (start) begin
			key_q <= key;
		end
	end

	// Search sequencer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			chk_s1  <= 1'b0;
			idx_q   <= '0;
			fill_q  <= '0;
			done_q  <= 1'b0;
			found_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				chk_s1 <= 1'b0;
				idx_q  <= '0;
			end else if (busy_q) begin
				chk_s1 <= issue;
				if (issue) begin
					idx_q <= idx_q + 1'b1;
				end
				if (hit || miss) begin
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
					found_q <= hit;
					ovf_q   <= miss && (fill_q == DEPTH_F);
				end
				if (wr) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (clear) begin
				fill_q <= '0;
			end
		end
	end

	assign res.done  = done_q;
	assign res.found = found_q;
	assign res.ovf   = ovf_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DEPTH_F)
		else $error("table fill beyond depth");

endmodule

// File: rtl/core/mnvd_arith.sv
// Shared multiplier with its step sequencer: squared distance, edge cross product, dot.
module mnvd_arith (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              tri_en,
	input  mnvd_pkg::vtx_t    v,
	input  mnvd_pkg::vtx_t    h0,
	input  mnvd_pkg::vtx_t    h1,
	output mnvd_pkg::ar_res_t res
);
	import mnvd_pkg::*;

	localparam logic [3:0] OP_SQX = 4'd0;
	localparam logic [3:0] OP_SQY = 4'd1;
	localparam logic [3:0] OP_SQZ = 4'd2;
	localparam logic [3:0] OP_CX0 = 4'd3;
	localparam logic [3:0] OP_CX1 = 4'd4;
	localparam logic [3:0] OP_CY0 = 4'd5;
	localparam logic [3:0] OP_CY1 = 4'd6;
	localparam logic [3:0] OP_CZ0 = 4'd7;
	localparam logic [3:0] OP_CZ1 = 4'd8;
	localparam logic [3:0] OP_DX  = 4'd9;
	localparam logic [3:0] OP_DY  = 4'd10;
	localparam logic [3:0] OP_DZ  = 4'd11;

	logic                     run_q;
	logic [3:0]               step_q;
	logic [3:0]               fin_q;
	logic                     pv_s1;
	logic [3:0]               tag_s1;
	logic signed [PW-1:0]     prod_s1;
	logic [35:0]              sq_q;
	crs_t                     cx_q;
	crs_t                     cy_q;
	crs_t                     cz_q;
	dot_t                     dot_q;
	logic                     done_q;

	logic signed [AW_OP-1:0] ax, ay, az, bx, by, bz;
	logic signed [AW_OP-1:0] opa;
	logic signed [BW_OP-1:0] opb;

	// Edges v1 - v0 and v2 - v1
	assign ax = AW_OP'(h1.x) - AW_OP'(h0.x);
	assign ay = AW_OP'(h1.y) - AW_OP'(h0.y);
	assign az = AW_OP'(h1.z) - AW_OP'(h0.z);
	assign bx = AW_OP'(v.x) - AW_OP'(h1.x);
	assign by = AW_OP'(v.y) - AW_OP'(h1.y);
	assign bz = AW_OP'(v.z) - AW_OP'(h1.z);

	// Operand selection for the current step
	always_comb begin
		case (step_q)
			OP_SQX: begin opa = AW_OP'(v.x); opb = BW_OP'(v.x); end
			OP_SQY: begin opa = AW_OP'(v.y); opb = BW_OP'(v.y); end
			OP_SQZ: begin opa = AW_OP'(v.z); opb = BW_OP'(v.z); end
			OP_CX0: begin opa = ay; opb = BW_OP'(bz); end
			OP_CX1: begin opa = az; opb = BW_OP'(by); end
			OP_CY0: begin opa = az; opb = BW_OP'(bx); end
			OP_CY1: begin opa = ax; opb = BW_OP'(bz); end
			OP_CZ0: begin opa = ax; opb = BW_OP'(by); end
			OP_CZ1: begin opa = ay; opb = BW_OP'(bx); end
			OP_DX:  begin opa = AW_OP'(h0.x); opb = cx_q; end
			OP_DY:  begin opa = AW_OP'(h0.y); opb = cy_q; end
			OP_DZ:  begin opa = AW_OP'(h0.z); opb = cz_q; end
			default: begin opa = '0; opb = '0; end
		endcase
	end

	// Step sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			step_q <= OP_SQX;
			fin_q  <= OP_SQZ;
			pv_s1  <= 1'b0;
			tag_s1 <= OP_SQX;
			done_q <= 1'b0;
		end else begin
			done_q <= pv_s1 && (tag_s1 == fin_q);
			pv_s1  <= run_q;
			tag_s1 <= step_q;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= OP_SQX;
				fin_q  <= tri_en ? OP_DZ : OP_SQZ;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == fin_q) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// Multiply into a registered product, then accumulate it in the cycle after
	always_ff @(posedge clk) begin
		prod_s1 <= PW'(opa) * PW'(opb);
		if (pv_s1) begin
			case (tag_s1)
				OP_SQX: sq_q  <= prod_s1[35:0];
				OP_SQY: sq_q  <= sq_q + prod_s1[35:0];
				OP_SQZ: sq_q  <= sq_q + prod_s1[35:0];
				OP_CX0: cx_q  <= prod_s1[BW_OP-1:0];
				OP_CX1: cx_q  <= cx_q - prod_s1[BW_OP-1:0];
				OP_CY0: cy_q  <= prod_s1[BW_OP-1:0];
				OP_CY1: cy_q  <= cy_q - prod_s1[BW_OP-1:0];
				OP_CZ0: cz_q  <= prod_s1[BW_OP-1:0];
				OP_CZ1: cz_q  <= cz_q - prod_s1[BW_OP-1:0];
				OP_DX:  dot_q <= DOT_W'(prod_s1);
				OP_DY:  dot_q <= dot_q + DOT_W'(prod_s1);
				OP_DZ:  dot_q <= dot_q + DOT_W'(prod_s1);
				default: ;
			endcase
		end
	end

	assign res.done = done_q;
	assign res.sq   = (|sq_q[35:32]) ? 32'hFFFF_FFFF : sq_q[31:0];
	assign res.cx   = cx_q;
	assign res.cy   = cy_q;
	assign res.cz   = cz_q;
	assign res.dot  = dot_q;

endmodule

// File: rtl/core/mesh_normal_volume_dedup.sv
// Top level: vertex sequencer, mesh accumulators, square root and result register.
//
// Vertices enter on the in_ channel (valid/stall); one request is accepted when
// in_valid is high and in_stall low. Every vertex gives exactly one result on the
// out_ channel, taken when out_valid is high and out_stall low.
// One vertex at a time is processed; in_stall stays high until its result has
// been placed in the output register. The vertex table is a single-port memory
// searched one entry per cycle, in parallel with the shared multiplier (3 steps
// for a plain vertex, 12 when it closes a triangle). The search walks the fill
// distinct vertices stored so far in this mesh and stops early on a hit; the
// result is built once both the search and the multiplier are done. The vertex
// marked last then adds a bit-by-bit square root of the maximum squared radius
// and clears all mesh state.
// Reset empties the table (fill count only, no clearing pass) and clears all
// accumulators. A stalled result holds in the output register; the next vertex
// may be accepted meanwhile and waits for the register to free before it leaves.
module mesh_normal_volume_dedup #(
	parameter int TABLE_DEPTH = 4096,
	parameter int COORD_BITS  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] x_coord,
	input  logic signed [15:0] y_coord,
	input  logic signed [15:0] z_coord,
	input  logic               last_vertex,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               is_new,
	output logic               table_overflow,
	output logic               normal_valid,
	output logic signed [33:0] normal_x,
	output logic signed [33:0] normal_y,
	output logic signed [33:0] normal_z,
	output logic               totals_valid,
	output logic signed [63:0] six_volume,
	output logic [15:0]        max_radius,
	output logic [31:0]        triangle_total
);
	import mnvd_pkg::*;

	localparam int  SH = (COORD_BITS < 16) ? 16 - COORD_BITS : 0;
	localparam bit  ZX = COORD_BITS > 16;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_WAIT = 4'b0010,
		ST_SQRT = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	function automatic crd_t ext_crd(input logic [15:0] c);
		logic signed [15:0] t;
		t = $signed(c << SH) >>> SH;
		return ZX ? {1'b0, c} : {t[15], t};
	endfunction

	state_t             st_q;
	vtx_t               v_q;
	vtx_t               h0_q;
	vtx_t               h1_q;
	logic               last_q;
	logic [1:0]         corner_q;
	logic signed [63:0] vol_q;
	logic [31:0]        maxsq_q;
	logic [31:0]        tri_q;
	logic               tdone_q;
	logic               adone_q;
	logic               found_q;
	logic               tovf_q;
	logic               start;
	logic               tclear;
	tbl_res_t           tres;
	ar_res_t            ares;

	// Pending result, built when the vertex is complete
	logic               p_new_q;
	logic               p_ovf_q;
	logic               p_nv_q;
	logic signed [33:0] p_nx_q, p_ny_q, p_nz_q;
	logic signed [63:0] p_vol_q;
	logic [31:0]        p_tri_q;

	// Square root
	logic [31:0] rem_q;
	logic [31:0] res_q;
	logic [31:0] bit_q;

	logic               out_valid_q;
	logic               is_new_q, ovf_q, nv_q, tv_q;
	logic signed [33:0] nx_q, ny_q, nz_q;
	logic signed [63:0] sv_q;
	logic [15:0]        mr_q;
	logic [31:0]        tt_q;

	logic               both_done;
	logic               tri_now;
	logic [31:0]        maxsq_new;
	logic signed [64:0] vsum;
	logic signed [63:0] vol_new;
	logic [31:0]        tri_new;
	logic [32:0]        trial;
	logic               out_free;

	assign start     = st_q == ST_IDLE && in_valid;
	assign in_stall  = st_q != ST_IDLE;
	assign both_done = (tdone_q || tres.done) && (adone_q || ares.done);
	assign tri_now   = corner_q[1];
	assign out_free  = !out_valid_q || !out_stall;
	assign tclear    = st_q == ST_OUT && out_free && last_q;

	mnvd_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.clear  (tclear),
		.key    ({ext_crd(x_coord), ext_crd(y_coord), ext_crd(z_coord)}),
		.res    (tres)
	);

	mnvd_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.tri_en (tri_now),
		.v      (v_q),
		.h0     (h0_q),
		.h1     (h1_q),
		.res    (ares)
	);

	// Accumulator updates for the finished vertex
	assign maxsq_new = (ares.sq > maxsq_q) ? ares.sq : maxsq_q;
	assign vsum      = 65'(vol_q) + 65'(ares.dot);
	assign vol_new   = !tri_now ? vol_q :
		(vsum[64] != vsum[63]) ? {vsum[64], {63{!vsum[64]}}} : vsum[63:0];
	assign tri_new   = (tri_now && tri_q != 32'hFFFF_FFFF) ? tri_q + 1'b1 : tri_q;
	assign trial     = 33'(res_q) + 33'(bit_q);

	// Vertex register, held stable for the multiply unit during the item; also the pending result and square root
	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= {ext_crd(x_coord), ext_crd(y_coord), ext_crd(z_coord)};
			last_q <= last_vertex;
		end
		if (tres.done) begin
			found_q <= tres.found;
			tovf_q  <= tres.ovf;
		end
		if (st_q == ST_WAIT && both_done) begin
			p_new_q <= !(tres.done ? tres.found : found_q);
			p_ovf_q <= tres.done ? tres.ovf : tovf_q;
			p_nv_q  <= tri_now;
			p_nx_q  <= tri_now ? ares.cx[33:0] : '0;
			p_ny_q  <= tri_now ? ares.cy[33:0] : '0;
			p_nz_q  <= tri_now ? ares.cz[33:0] : '0;
			p_vol_q <= vol_new;
			p_tri_q <= tri_new;
			rem_q   <= maxsq_new;
			res_q   <= '0;
			bit_q   <= 32'h4000_0000;
		end else if (st_q == ST_SQRT && bit_q != '0) begin
			// One result bit per cycle
			if (33'(rem_q) >= trial) begin
				rem_q <= rem_q - trial[31:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	// Sequencer and mesh state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			tdone_q  <= 1'b0;
			adone_q  <= 1'b0;
			corner_q <= '0;
			h0_q     <= '0;
			h1_q     <= '0;
			vol_q    <= '0;
			maxsq_q  <= '0;
			tri_q    <= '0;
		end else begin
			if (tres.done) tdone_q <= 1'b1;
			if (ares.done) adone_q <= 1'b1;
			case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						st_q    <= ST_WAIT;
						tdone_q <= 1'b0;
						adone_q <= 1'b0;
					end
				end
				ST_WAIT: begin
					if (both_done) begin
						maxsq_q <= maxsq_new;
						vol_q   <= vol_new;
						tri_q   <= tri_new;
						if (tri_now) begin
							corner_q <= '0;
						end else begin
							if (corner_q[0]) h1_q <= v_q;
							else             h0_q <= v_q;
							corner_q <= corner_q + 1'b1;
						end
						st_q <= last_q ? ST_SQRT : ST_OUT;
					end
				end
				ST_SQRT: begin
					if (bit_q == '0) st_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						st_q <= ST_IDLE;
						if (last_q) begin
							corner_q <= '0;
							h0_q     <= '0;
							h1_q     <= '0;
							vol_q    <= '0;
							maxsq_q  <= '0;
							tri_q    <= '0;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (st_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_OUT && out_free) begin
			is_new_q <= p_new_q;
			ovf_q    <= p_ovf_q;
			nv_q     <= p_nv_q;
			nx_q     <= p_nx_q;
			ny_q     <= p_ny_q;
			nz_q     <= p_nz_q;
			tv_q     <= last_q;
			sv_q     <= last_q ? p_vol_q : '0;
			mr_q     <= last_q ? res_q[15:0] : '0;
			tt_q     <= last_q ? p_tri_q : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign is_new         = is_new_q;
	assign table_overflow = ovf_q;
	assign normal_valid   = nv_q;
	assign normal_x       = nx_q;
	assign normal_y       = ny_q;
	assign normal_z       = nz_q;
	assign totals_valid   = tv_q;
	assign six_volume     = sv_q;
	assign max_radius     = mr_q;
	assign triangle_total = tt_q;

	a_corner: assert property (@(posedge clk) disable iff (!arst_n)
		corner_q != 2'd3)
		else $error("corner index out of range");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted without entering busy");

	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_overflow |-> is_new)
		else $error("overflow on a known vertex");

	a_totals: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !totals_valid |-> six_volume == '0 && max_radius == '0
			&& triangle_total == '0)
		else $error("totals without last vertex");

endmodule
